// ===== sv/ncdf_pkg.sv =====
// ----------------------------------------------------------------------------
// ncdf_pkg
// Widths, fixed-point constants and pipeline payload types shared by the
// normal CDF pipeline. Every intermediate value carries 28 fraction bits.
// ----------------------------------------------------------------------------
package ncdf_pkg;

    localparam int X_WIDTH_DEF   = 16;
    localparam int CDF_WIDTH_DEF = 16;

    localparam int FB    = 28;          // fraction bits of all intermediates
    localparam int T_W   = FB + 1;      // t and erfc never exceed 1.0
    localparam int Z_W   = 31;          // z = |x|/sqrt(2) stays below 6.0
    localparam int D_W   = 32;          // divisor 2 + z
    localparam int ZZ_W  = 34;          // z*z stays below 33.0
    localparam int ACC_W = 32;          // Horner accumulator, signed
    localparam int M_W   = 33;          // exponent magnitude, saturated
    localparam int N_W   = 6;           // integer part of the base-2 exponent
    localparam int U_W   = FB;          // reduced argument below ln 2
    localparam int S_W   = FB + 1;      // Taylor partial sum, at most 1.0
    localparam int L_W   = 29;          // width of the log2(e) constant

    localparam int HORNER_STEPS = 9;
    localparam int TAYLOR_TERMS = 12;
    localparam int N_TAIL       = 30;   // exp underflows to zero from here on

    localparam longint unsigned ONE = 64'd1 << FB;

    localparam logic [27:0] KSQ =
        28'(((64'd100000000 << FB) + 64'd70710678) / 64'd141421356);
    localparam logic [L_W-1:0] LOG2E_Q = 29'd387270501;
    localparam logic [U_W-1:0] LN2_Q   = 28'd186065279;

    // Decimal coefficient scaled by 1e8 to Q.28, rounded to nearest.
    function automatic logic signed [ACC_W-1:0] e8q(input longint unsigned v);
        longint unsigned m;
        m = ((v << FB) + 64'd50000000) / 64'd100000000;
        return $signed(ACC_W'(m));
    endfunction

    localparam logic signed [ACC_W-1:0] COEF [HORNER_STEPS+1] = '{
        -e8q(64'd126551223),
         e8q(64'd100002368),
         e8q(64'd37409196),
         e8q(64'd9678418),
        -e8q(64'd18628806),
         e8q(64'd27886807),
        -e8q(64'd113520398),
         e8q(64'd148851587),
        -e8q(64'd82215223),
         e8q(64'd17087277)
    };

    // Values that ride along the pipeline next to the working data.
    typedef struct packed {
        logic            neg;
        logic [ZZ_W-1:0] zz;
        logic [T_W-1:0]  t;
        logic [N_W-1:0]  n;
    } side_t;

    typedef struct packed {
        logic [D_W-1:0] rem;
        logic [T_W-1:0] nl;
        logic [T_W-1:0] q;
        logic [D_W-1:0] d;
    } div_state_t;

    typedef struct packed {
        logic [U_W-1:0] u;
        logic [S_W-1:0] s;
    } tay_t;

endpackage

// ===== sv/ncdf_if.sv =====
// ----------------------------------------------------------------------------
// ncdf_if
// Valid/ready channels of the normal CDF block: argument beats in,
// CDF beats out.
// ----------------------------------------------------------------------------
interface ncdf_x_if #(parameter int X_WIDTH = ncdf_pkg::X_WIDTH_DEF);
    logic                      valid;
    logic                      ready;
    logic signed [X_WIDTH-1:0] x_value;

    modport source (output valid, output x_value, input ready);
    modport sink (input valid, input x_value, output ready);
endinterface

interface ncdf_cdf_if #(parameter int CDF_WIDTH = ncdf_pkg::CDF_WIDTH_DEF);
    logic                 valid;
    logic                 ready;
    logic [CDF_WIDTH-1:0] cdf_value;

    modport source (output valid, output cdf_value, input ready);
    modport sink (input valid, input cdf_value, output ready);
endinterface

// ===== sv/ncdf_div_cell.sv =====
// ----------------------------------------------------------------------------
// ncdf_div_cell
// One cell of the restoring divider for t = 2/(2+z): it retires one quotient
// bit per cycle while advance is high and passes the partial remainder on.
// ----------------------------------------------------------------------------
module ncdf_div_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   prev_valid,
    input  ncdf_pkg::div_state_t   prev_div,
    input  ncdf_pkg::side_t        prev_side,
    output logic                   valid,
    output ncdf_pkg::div_state_t   div,
    output ncdf_pkg::side_t        side
);

    localparam int D_W = ncdf_pkg::D_W;
    localparam int T_W = ncdf_pkg::T_W;

    logic                 valid_reg;
    ncdf_pkg::div_state_t div_reg;
    ncdf_pkg::div_state_t div_next;
    ncdf_pkg::side_t      side_reg;
    logic [D_W:0]         trial;
    logic                 take;

    assign trial = {prev_div.rem, prev_div.nl[T_W-1]};
    assign take  = trial >= {1'b0, prev_div.d};

    always_comb
    begin
        div_next.rem = take ? D_W'(trial - {1'b0, prev_div.d}) : trial[D_W-1:0];
        div_next.nl  = {prev_div.nl[T_W-2:0], 1'b0};
        div_next.q   = {prev_div.q[T_W-2:0], take};
        div_next.d   = prev_div.d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_reg  <= div_next;
            side_reg <= prev_side;
        end
    end

    assign valid = valid_reg;
    assign div   = div_reg;
    assign side  = side_reg;

endmodule

// ===== sv/ncdf_horner_cell.sv =====
// ----------------------------------------------------------------------------
// ncdf_horner_cell
// One Horner step of the erfc exponent polynomial: acc = COEF + acc*t,
// with the product rounded on its magnitude. Two register stages.
// ----------------------------------------------------------------------------
module ncdf_horner_cell #(
    parameter logic signed [ncdf_pkg::ACC_W-1:0] COEF = '0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               prev_valid,
    input  logic signed [ncdf_pkg::ACC_W-1:0]  prev_acc,
    input  ncdf_pkg::side_t                    prev_side,
    output logic                               valid,
    output logic signed [ncdf_pkg::ACC_W-1:0]  acc,
    output ncdf_pkg::side_t                    side
);

    localparam int ACC_W = ncdf_pkg::ACC_W;
    localparam int FB    = ncdf_pkg::FB;
    localparam int P_W   = ACC_W + ncdf_pkg::T_W;

    logic                    mul_valid_reg;
    logic [P_W-1:0]          prod_reg;
    logic                    neg_reg;
    ncdf_pkg::side_t         mul_side_reg;
    logic [ACC_W-1:0]        mag;
    logic [ACC_W:0]          rnd;
    logic signed [ACC_W+1:0] term;
    logic signed [ACC_W+1:0] sum;
    logic                    valid_reg;
    logic signed [ACC_W-1:0] acc_reg;
    ncdf_pkg::side_t         side_reg;

    assign mag = prev_acc[ACC_W-1] ? ACC_W'(-prev_acc) : ACC_W'(prev_acc);

    assign rnd  = (ACC_W+1)'((prod_reg + (P_W'(1) << (FB - 1))) >> FB);
    assign term = neg_reg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
    assign sum  = (ACC_W+2)'(COEF) + term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (advance)
        begin
            mul_valid_reg <= prev_valid;
            valid_reg     <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg     <= P_W'(mag) * P_W'(prev_side.t);
            neg_reg      <= prev_acc[ACC_W-1];
            mul_side_reg <= prev_side;
            acc_reg      <= $signed(sum[ACC_W-1:0]);
            side_reg     <= mul_side_reg;
        end
    end

    assign valid = valid_reg;
    assign acc   = acc_reg;
    assign side  = side_reg;

endmodule

// ===== sv/ncdf_taylor_cell.sv =====
// ----------------------------------------------------------------------------
// ncdf_taylor_cell
// One Horner term of the exp(-u) Taylor series: s = 1 - round(u*s/K).
// The division by K is a reciprocal multiply with a one-step correction.
// Three register stages.
// ----------------------------------------------------------------------------
module ncdf_taylor_cell #(
    parameter int K = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            prev_valid,
    input  ncdf_pkg::tay_t  prev_tay,
    input  ncdf_pkg::side_t prev_side,
    output logic            valid,
    output ncdf_pkg::tay_t  tay,
    output ncdf_pkg::side_t side
);

    localparam int FB  = ncdf_pkg::FB;
    localparam int U_W = ncdf_pkg::U_W;
    localparam int S_W = ncdf_pkg::S_W;
    localparam int P_W = U_W + S_W;
    localparam int Y_W = FB + 1;
    localparam int R_W = 32;
    localparam int Q_W = Y_W + R_W;
    localparam logic [R_W-1:0] RCP  = R_W'(64'hFFFF_FFFF / K);
    localparam logic [P_W-1:0] BIAS = P_W'(K) << (FB - 1);

    logic            v1_reg;
    logic [P_W-1:0]  p_reg;
    logic [U_W-1:0]  u1_reg;
    ncdf_pkg::side_t side1_reg;

    logic            v2_reg;
    logic [Y_W-1:0]  y_reg;
    logic [Y_W-1:0]  q0_reg;
    logic [U_W-1:0]  u2_reg;
    ncdf_pkg::side_t side2_reg;

    logic            valid_reg;
    ncdf_pkg::tay_t  tay_reg;
    ncdf_pkg::side_t side_reg;

    logic [Y_W-1:0]  y;
    logic [Q_W-1:0]  qprod;
    logic [Y_W:0]    kq;
    logic [Y_W:0]    rem;
    logic [Y_W-1:0]  q;
    ncdf_pkg::tay_t  tay_next;

    assign y     = Y_W'(p_reg >> FB);
    assign qprod = Q_W'(y) * Q_W'(RCP);

    // The estimate is the quotient or one below it.
    assign kq  = (Y_W+1)'(q0_reg) * (Y_W+1)'(K);
    assign rem = {1'b0, y_reg} - kq;
    assign q   = (rem >= (Y_W+1)'(K)) ? q0_reg + 1'b1 : q0_reg;

    always_comb
    begin
        tay_next.u = u2_reg;
        tay_next.s = S_W'(ncdf_pkg::ONE) - S_W'(q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg    <= prev_valid;
            v2_reg    <= v1_reg;
            valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_reg     <= P_W'(prev_tay.u) * P_W'(prev_tay.s) + BIAS;
            u1_reg    <= prev_tay.u;
            side1_reg <= prev_side;
            y_reg     <= y;
            q0_reg    <= Y_W'(qprod >> R_W);
            u2_reg    <= u1_reg;
            side2_reg <= side1_reg;
            tay_reg   <= tay_next;
            side_reg  <= side2_reg;
        end
    end

    assign valid = valid_reg;
    assign tay   = tay_reg;
    assign side  = side_reg;

endmodule

// ===== sv/normal_cdf_approximation.sv =====
// ----------------------------------------------------------------------------
// normal_cdf_approximation
// Standard normal CDF of a signed fixed-point argument, fully pipelined.
// Throughput: one beat per cycle unless the output buffer stalls, set by the
// 29-cell divider, 9 Horner cells and 12 Taylor cells that each hand data to
// the next every cycle.
// A two-entry output buffer stalls the whole pipeline only when both are full.
// Reset clears every valid flag; no item survives reset.
// ----------------------------------------------------------------------------
module normal_cdf_approximation #(
    parameter int X_WIDTH   = ncdf_pkg::X_WIDTH_DEF,
    parameter int CDF_WIDTH = ncdf_pkg::CDF_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    ncdf_x_if.sink            sample,
    ncdf_cdf_if.source        result
);

    localparam int FB    = ncdf_pkg::FB;
    localparam int T_W   = ncdf_pkg::T_W;
    localparam int Z_W   = ncdf_pkg::Z_W;
    localparam int D_W   = ncdf_pkg::D_W;
    localparam int ZZ_W  = ncdf_pkg::ZZ_W;
    localparam int ACC_W = ncdf_pkg::ACC_W;
    localparam int M_W   = ncdf_pkg::M_W;
    localparam int N_W   = ncdf_pkg::N_W;
    localparam int U_W   = ncdf_pkg::U_W;
    localparam int S_W   = ncdf_pkg::S_W;
    localparam int L_W   = ncdf_pkg::L_W;
    localparam int HS    = ncdf_pkg::HORNER_STEPS;
    localparam int TT    = ncdf_pkg::TAYLOR_TERMS;
    localparam int XF    = X_WIDTH - 4;
    localparam int ZP_W  = X_WIDTH + 28;
    localparam int E_W   = ZZ_W + 2;
    localparam int M_LO  = 16;
    localparam int YF_W  = M_W + L_W;
    localparam int Y_W   = YF_W - FB;
    localparam int UP_W  = 2 * U_W;
    localparam int EP_W  = 2 * T_W;
    localparam int H_W   = CDF_WIDTH + 1;

    logic advance;

    // ---------------- front end: z and z*z ----------------
    logic [X_WIDTH-1:0] x_raw;
    logic               x_neg;
    logic [X_WIDTH-1:0] x_mag;
    logic [ZP_W-1:0]    zsum;
    logic [2*Z_W-1:0]   zsq;

    logic               f1_valid_reg;
    logic               f1_neg_reg;
    logic [Z_W-1:0]     f1_z_reg;
    logic               f2_valid_reg;
    logic               f2_neg_reg;
    logic [D_W-1:0]     f2_d_reg;
    logic [ZZ_W-1:0]    f2_zz_reg;

    assign x_raw = sample.x_value;
    assign x_neg = x_raw[X_WIDTH-1];
    assign x_mag = x_neg ? X_WIDTH'(~x_raw + 1'b1) : x_raw;
    assign zsum  = ZP_W'(x_mag) * ZP_W'(ncdf_pkg::KSQ) + (ZP_W'(1) << (XF - 1));
    assign zsq   = (2*Z_W)'(f1_z_reg) * (2*Z_W)'(f1_z_reg) + ((2*Z_W)'(1) << (FB - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            f1_valid_reg <= sample.valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f1_neg_reg <= x_neg;
            f1_z_reg   <= Z_W'(zsum >> XF);
            f2_neg_reg <= f1_neg_reg;
            f2_d_reg   <= (D_W'(1) << (FB + 1)) + D_W'(f1_z_reg);
            f2_zz_reg  <= ZZ_W'(zsq >> FB);
        end
    end

    // ---------------- divider: t = 2^57 / (2^29 + z), rounded ----------------
    logic                 div_valid [0:T_W];
    ncdf_pkg::div_state_t div_chain [0:T_W];
    ncdf_pkg::side_t      div_side  [0:T_W];

    // The numerator is 2^57 plus half the divisor for rounding.
    assign div_valid[0]     = f2_valid_reg;
    assign div_chain[0].rem = D_W'(ncdf_pkg::ONE) + D_W'(f2_d_reg >> (FB + 2));
    assign div_chain[0].nl  = f2_d_reg[FB+1:1];
    assign div_chain[0].q   = '0;
    assign div_chain[0].d   = f2_d_reg;
    assign div_side[0].neg  = f2_neg_reg;
    assign div_side[0].zz   = f2_zz_reg;
    assign div_side[0].t    = '0;
    assign div_side[0].n    = '0;

    for (genvar i = 0; i < T_W; i++)
    begin : g_div
        ncdf_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (div_valid[i]),
            .prev_div   (div_chain[i]),
            .prev_side  (div_side[i]),
            .valid      (div_valid[i+1]),
            .div        (div_chain[i+1]),
            .side       (div_side[i+1])
        );
    end

    // ---------------- Horner polynomial P(t) ----------------
    logic                    hor_valid [0:HS];
    logic signed [ACC_W-1:0] hor_acc   [0:HS];
    ncdf_pkg::side_t         hor_side  [0:HS];

    assign hor_valid[0]    = div_valid[T_W];
    assign hor_acc[0]      = ncdf_pkg::COEF[HS];
    assign hor_side[0].neg = div_side[T_W].neg;
    assign hor_side[0].zz  = div_side[T_W].zz;
    assign hor_side[0].t   = div_chain[T_W].q;
    assign hor_side[0].n   = div_side[T_W].n;

    for (genvar j = 0; j < HS; j++)
    begin : g_horner
        ncdf_horner_cell #(
            .COEF (ncdf_pkg::COEF[HS-1-j])
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (hor_valid[j]),
            .prev_acc   (hor_acc[j]),
            .prev_side  (hor_side[j]),
            .valid      (hor_valid[j+1]),
            .acc        (hor_acc[j+1]),
            .side       (hor_side[j+1])
        );
    end

    // ---------------- exponent reduction ----------------
    logic signed [E_W-1:0] e_val;
    logic [E_W-1:0]        e_mag;
    logic [YF_W-1:0]       y_full;
    logic [Y_W-1:0]        y_num;
    logic [UP_W-1:0]       u_prod;

    logic                  e1_valid_reg;
    logic [M_W-1:0]        e1_m_reg;
    ncdf_pkg::side_t       e1_side_reg;
    logic                  e2_valid_reg;
    logic [M_W-M_LO+L_W-1:0] e2_phi_reg;
    logic [M_LO+L_W-1:0]   e2_plo_reg;
    ncdf_pkg::side_t       e2_side_reg;
    logic                  e3_valid_reg;
    logic [FB-1:0]         e3_f_reg;
    ncdf_pkg::side_t       e3_side_reg;
    logic                  e4_valid_reg;
    ncdf_pkg::tay_t        e4_tay_reg;
    ncdf_pkg::side_t       e4_side_reg;

    // A slightly positive exponent near zero is clamped so exp stays at 1.
    assign e_val = E_W'(hor_acc[HS]) - $signed({2'b00, hor_side[HS].zz});
    assign e_mag = (e_val > 0) ? '0 : E_W'(-e_val);

    assign y_full = (YF_W'(e2_phi_reg) << M_LO) + YF_W'(e2_plo_reg)
                    + (YF_W'(1) << (FB - 1));
    assign y_num  = Y_W'(y_full >> FB);
    assign u_prod = UP_W'(e3_f_reg) * UP_W'(ncdf_pkg::LN2_Q) + (UP_W'(1) << (FB - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
            e3_valid_reg <= 1'b0;
            e4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            e1_valid_reg <= hor_valid[HS];
            e2_valid_reg <= e1_valid_reg;
            e3_valid_reg <= e2_valid_reg;
            e4_valid_reg <= e3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // Anything this large is deep in the tail either way.
            e1_m_reg    <= (|e_mag[E_W-1:M_W]) ? '1 : e_mag[M_W-1:0];
            e1_side_reg <= hor_side[HS];
            e2_phi_reg  <= (M_W-M_LO+L_W)'(e1_m_reg[M_W-1:M_LO])
                           * (M_W-M_LO+L_W)'(ncdf_pkg::LOG2E_Q);
            e2_plo_reg  <= (M_LO+L_W)'(e1_m_reg[M_LO-1:0])
                           * (M_LO+L_W)'(ncdf_pkg::LOG2E_Q);
            e2_side_reg <= e1_side_reg;
            e3_f_reg    <= y_num[FB-1:0];
            e3_side_reg.neg <= e2_side_reg.neg;
            e3_side_reg.zz  <= e2_side_reg.zz;
            e3_side_reg.t   <= e2_side_reg.t;
            e3_side_reg.n   <= y_num[FB +: N_W];
            e4_tay_reg.u <= U_W'(u_prod >> FB);
            e4_tay_reg.s <= S_W'(ncdf_pkg::ONE);
            e4_side_reg <= e3_side_reg;
        end
    end

    // ---------------- Taylor series for exp(-u) ----------------
    logic            tay_valid [0:TT];
    ncdf_pkg::tay_t  tay_chain [0:TT];
    ncdf_pkg::side_t tay_side  [0:TT];

    assign tay_valid[0] = e4_valid_reg;
    assign tay_chain[0] = e4_tay_reg;
    assign tay_side[0]  = e4_side_reg;

    for (genvar k = 0; k < TT; k++)
    begin : g_taylor
        ncdf_taylor_cell #(
            .K (TT - k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (tay_valid[k]),
            .prev_tay   (tay_chain[k]),
            .prev_side  (tay_side[k]),
            .valid      (tay_valid[k+1]),
            .tay        (tay_chain[k+1]),
            .side       (tay_side[k+1])
        );
    end

    // ---------------- scale by 2^-n, multiply by t, finish ----------------
    logic [S_W:0]     half;
    logic [S_W:0]     shifted;
    logic [EP_W-1:0]  erfc_prod;
    logic [T_W:0]     h_sum;
    logic [H_W-1:0]   h_raw;
    logic [H_W-1:0]   h_val;
    logic [H_W-1:0]   r_val;
    logic [CDF_WIDTH-1:0] res_val;

    logic             b1_valid_reg;
    logic [T_W-1:0]   b1_ex_reg;
    logic [T_W-1:0]   b1_t_reg;
    logic             b1_neg_reg;
    logic             b2_valid_reg;
    logic [T_W-1:0]   b2_erfc_reg;
    logic             b2_neg_reg;

    assign half    = (tay_side[TT].n == '0) ? '0
                     : (S_W+1)'(1) << (tay_side[TT].n - 1'b1);
    assign shifted = ({1'b0, tay_chain[TT].s} + half) >> tay_side[TT].n;

    assign erfc_prod = EP_W'(b1_t_reg) * EP_W'(b1_ex_reg) + (EP_W'(1) << (FB - 1));

    assign h_sum   = {1'b0, b2_erfc_reg} + ((T_W+1)'(1) << (FB - CDF_WIDTH));
    assign h_raw   = H_W'(h_sum >> (FB + 1 - CDF_WIDTH));
    assign h_val   = (h_raw > (H_W'(1) << CDF_WIDTH)) ? (H_W'(1) << CDF_WIDTH) : h_raw;
    assign r_val   = b2_neg_reg ? h_val : (H_W'(1) << CDF_WIDTH) - h_val;
    assign res_val = r_val[CDF_WIDTH] ? '1 : r_val[CDF_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b1_valid_reg <= tay_valid[TT];
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_ex_reg   <= (tay_side[TT].n >= N_W'(ncdf_pkg::N_TAIL)) ? '0 : T_W'(shifted);
            b1_t_reg    <= tay_side[TT].t;
            b1_neg_reg  <= tay_side[TT].neg;
            b2_erfc_reg <= T_W'(erfc_prod >> FB);
            b2_neg_reg  <= b1_neg_reg;
        end
    end

    // ---------------- output register with a skid entry ----------------
    logic                 out_valid_reg;
    logic [CDF_WIDTH-1:0] out_data_reg;
    logic                 skid_valid_reg;
    logic [CDF_WIDTH-1:0] skid_data_reg;

    // The pipeline moves whenever the skid entry is free, so a waiting
    // result does not hold up new sample beats.
    assign advance = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (result.ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (b2_valid_reg)
        begin
            if (!out_valid_reg || result.ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (result.ready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (b2_valid_reg)
        begin
            if (!out_valid_reg || result.ready)
            begin
                out_data_reg <= res_val;
            end
            else
            begin
                skid_data_reg <= res_val;
            end
        end
    end

    assign sample.ready     = advance;
    assign result.valid     = out_valid_reg;
    assign result.cdf_value = out_data_reg;

endmodule

// ===== dv/normal_cdf_approximation_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// normal_cdf_approximation_test
// Self-checking bench for the normal CDF pipeline: random and directed
// arguments are pushed through the valid/ready input, every result beat is
// compared with a bit-exact fixed-point prediction of the CDF.
// ----------------------------------------------------------------------------
module normal_cdf_approximation_test;

    localparam int XW = ncdf_pkg::X_WIDTH_DEF;
    localparam int CW = ncdf_pkg::CDF_WIDTH_DEF;
    localparam int FB = ncdf_pkg::FB;
    localparam longint unsigned ONE = ncdf_pkg::ONE;
    localparam int LATENCY = 92;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;

    ncdf_x_if #(.X_WIDTH(XW)) sample ();
    ncdf_cdf_if #(.CDF_WIDTH(CW)) result ();

    normal_cdf_approximation #(.X_WIDTH(XW), .CDF_WIDTH(CW)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source)
    );

    logic [XW-1:0] pending_args[$];
    logic [CW-1:0] expected_cdf[$];
    int errors = 0;
    int results_seen = 0;
    int args_sent = 0;
    bit quiet_phase = 0;      // no idling on either side
    bit hold_request = 0;     // asks the receiver for a long hold-off
    bit hold_sink;            // receiver is holding off
    int hold_cycles;
    bit drain_wait = 0;       // sender pauses until the block is empty
    int idle_cycles = 0;

    function automatic longint signed round_mul(longint signed a, longint unsigned b);
        longint unsigned mag;
        longint unsigned p;
        mag = (a < 0) ? longint'(-a) : a;
        p = (mag * b + (ONE >> 1)) >> FB;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned exp_of_neg(longint unsigned m);
        longint unsigned y, n, f, u, s, den, q;
        y = (m * longint'(ncdf_pkg::LOG2E_Q) + (ONE >> 1)) >> FB;
        n = y >> FB;
        f = y & (ONE - 1);
        u = (f * longint'(ncdf_pkg::LN2_Q) + (ONE >> 1)) >> FB;
        s = ONE;
        if (n >= ncdf_pkg::N_TAIL)
            return 0;
        for (int k = ncdf_pkg::TAYLOR_TERMS; k >= 1; k--)
        begin
            den = longint'(k) << FB;
            q = (u * s + (den >> 1)) / den;
            s = ONE - q;
        end
        if (n == 0)
            return s;
        return (s + (64'd1 << (n - 1))) >> n;
    endfunction

    function automatic logic [CW-1:0] normal_cdf(logic [XW-1:0] raw);
        bit neg;
        longint unsigned a, z, d, t, zz, m, ex, erfc, h, full, r;
        longint signed acc, e;
        neg = raw[XW-1];
        a = neg ? ((64'd1 << XW) - raw) : raw;
        z = (a * longint'(ncdf_pkg::KSQ) + (64'd1 << (XW - 5))) >> (XW - 4);
        d = 2 * ONE + z;
        t = ((64'd1 << (2 * FB + 1)) + (d >> 1)) / d;
        acc = ncdf_pkg::COEF[ncdf_pkg::HORNER_STEPS];
        for (int i = ncdf_pkg::HORNER_STEPS - 1; i >= 0; i--)
            acc = longint'(ncdf_pkg::COEF[i]) + round_mul(acc, t);
        zz = (z * z + (ONE >> 1)) >> FB;
        e = acc - longint'(zz);
        if (e > 0)
            e = 0;
        m = -e;
        ex = exp_of_neg(m);
        erfc = (t * ex + (ONE >> 1)) >> FB;
        h = (erfc + (64'd1 << (FB - CW))) >> (FB + 1 - CW);
        full = 64'd1 << CW;
        if (h > full)
            h = full;
        r = neg ? h : full - h;
        if (r > full - 1)
            r = full - 1;
        return r[CW-1:0];
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
    end

    // Driver: one beat offered per cycle while the block accepts, unless idling or paused.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample.valid <= 0;
            sample.x_value <= '0;
        end
        else
        begin
            logic fire;
            logic offer;
            fire = sample.valid && sample.ready;
            if (fire)
            begin
                expected_cdf.push_back(normal_cdf(sample.x_value));
                args_sent++;
            end
            offer = (!sample.valid || fire) ? 1'b0 : 1'b1;
            if (!offer && pending_args.size() > 0 && !drain_wait
                && (quiet_phase || $urandom_range(99) >= 37))
            begin
                sample.valid <= 1;
                sample.x_value <= pending_args.pop_front();
            end
            else if (!offer)
                sample.valid <= 0;
        end
    end

    // Receiver hold-off, timed by its own cycle counter.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_sink <= 0;
            hold_cycles <= 0;
        end
        else if (hold_sink)
        begin
            if (hold_cycles == 1)
                hold_sink <= 0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (hold_request)
        begin
            hold_sink <= 1;
            hold_cycles <= HOLD_CYCLES;
        end
    end

    // Monitor and receiver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 0;
        else
        begin
            if (result.valid && result.ready)
            begin
                results_seen++;
                if (expected_cdf.size() == 0)
                begin
                    $error("cdf_value: unexpected beat %0d", result.cdf_value);
                    errors++;
                end
                else
                begin
                    logic [CW-1:0] want;
                    want = expected_cdf.pop_front();
                    if (want !== result.cdf_value)
                    begin
                        $error("cdf_value: expected %0d, actual %0d", want, result.cdf_value);
                        errors++;
                    end
                end
            end
            result.ready <= !hold_sink && (quiet_phase || $urandom_range(99) >= 37);
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready)
            || pending_args.size() == 0 && expected_cdf.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_args.size() > 0 || sample.valid || expected_cdf.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [XW-1:0] directed[$];
        directed = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
                     16'h1000, 16'hF000, 16'h2000, 16'hE000, 16'h3000, 16'hD000,
                     16'h0010, 16'hFFF0, 16'h5555, 16'hAAAA, 16'h6000, 16'hA000,
                     16'h0800, 16'hF800, 16'h4000, 16'hC000};
        @(posedge rst_n);
        foreach (directed[i])
            pending_args.push_back(directed[i]);
        wait_drained();

        // Receiver holds off while the sender keeps offering.
        for (int i = 0; i < 200; i++)
            pending_args.push_back(XW'($urandom_range(16'hFFFF)));
        hold_request = 1;
        @(posedge hold_sink);
        hold_request = 0;
        @(negedge hold_sink);
        wait_drained();

        // Sender pauses with beats in flight until every result has come back.
        for (int i = 0; i < 30; i++)
            pending_args.push_back(XW'($urandom_range(16'hFFFF)));
        repeat (20) @(posedge clk);
        drain_wait = 1;
        while (sample.valid || expected_cdf.size() > 0)
            @(posedge clk);
        drain_wait = 0;
        wait_drained();

        for (int i = 0; i < 1000; i++)
        begin
            if (i == 400)
            begin
                wait_drained();
                quiet_phase = 1;
            end
            if (i == 600)
            begin
                wait_drained();
                quiet_phase = 0;
            end
            // Mostly the interesting range |x| <= 6, sometimes anything.
            if ($urandom_range(3) != 0)
                pending_args.push_back(XW'($signed($urandom_range(49152)) - 24576));
            else
                pending_args.push_back(XW'($urandom_range(16'hFFFF)));
        end
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        $display("Checked %0d CDF results from %0d arguments, with directed extremes,",
                 results_seen, args_sent);
        $display("long output stalls, a full drain pause and back-to-back bursts.");
        if (errors == 0 && expected_cdf.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== normal_cdf_approximation.f =====
sv/ncdf_pkg.sv
sv/ncdf_if.sv
sv/ncdf_div_cell.sv
sv/ncdf_horner_cell.sv
sv/ncdf_taylor_cell.sv
sv/normal_cdf_approximation.sv
dv/normal_cdf_approximation_test.sv
